>>> sv/chained_hash_table_macros.svh
// Assertion macros used by the checker file
`ifndef CHAINED_HASH_TABLE_MACROS_SVH
`define CHAINED_HASH_TABLE_MACROS_SVH
// clocked implication with synchronous reset qualifier
`define CHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication with synchronous reset qualifier
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> sv/cht_pkg.sv
// Types and codes for the chained hash table
package cht_pkg;
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam int KEY_W = 17;
    localparam int BKT_W = 4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [16:0] record_key;
        logic [63:0] name_low;
        logic [55:0] name_high;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  bucket;
        logic [63:0] found_name_low;
        logic [55:0] found_name_high;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  operation;
        logic [16:0] record_key;
        logic [63:0] name_low;
        logic [55:0] name_high;
        logic [3:0]  bucket;
    } t_job;
endpackage

>>> sv/cht_front.sv
// Front end: accepts operations and reduces the key to a bucket index
module cht_front #(
    parameter int BUCKETS = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cht_pkg::t_in_item i_item,
    input  logic             i_push,
    output logic             o_full,
    output cht_pkg::t_job    o_job,
    output logic             o_job_valid,
    input  logic             i_job_ready
);
    import cht_pkg::*;

    localparam int SH = KEY_W + $clog2(BUCKETS) + 1;
    localparam longint unsigned MUL = ((longint'(1) << SH) + BUCKETS - 1) / BUCKETS;
    localparam int MW = $clog2(MUL + 1);
    localparam int PW = KEY_W + MW;

    // key mod BUCKETS by reciprocal multiplication
    typedef enum logic [1:0] {S_IDLE, S_RED, S_OUT} t_state;
    t_state r_state;
    t_in_item r_item;
    logic [KEY_W-1:0] r_rem;
    logic [PW-1:0] w_prod;
    logic [KEY_W-1:0] w_quo;
    logic [KEY_W-1:0] w_rem;

    assign w_prod = PW'(r_item.record_key) * PW'(MUL);
    assign w_quo = KEY_W'(w_prod >> SH);
    assign w_rem = r_item.record_key - KEY_W'(w_quo * KEY_W'(BUCKETS));
    assign o_full = (r_state != S_IDLE);
    assign o_job_valid = (r_state == S_OUT);
    always_comb begin
        o_job.operation  = r_item.operation;
        o_job.record_key = r_item.record_key;
        o_job.name_low   = r_item.name_low;
        o_job.name_high  = r_item.name_high;
        o_job.bucket     = BKT_W'(r_rem);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_item  <= i_item;
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    r_rem   <= w_rem;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_job_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> sv/cht_queue.sv
// Two-entry queue between the front and back ends
module cht_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cht_pkg::t_job i_job,
    input  logic          i_valid,
    output logic          o_ready,
    output cht_pkg::t_job o_job,
    output logic          o_valid,
    input  logic          i_ready
);
    import cht_pkg::*;

    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_wr, w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_wr = i_valid && o_ready;
    assign w_rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end
endmodule

>>> sv/cht_back.sv
// Back end: walks the chains in the node pool and forms results
module cht_back #(
    parameter int BUCKETS = 9,
    parameter int POOL_NODES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cht_pkg::t_job     i_job,
    input  logic              i_valid,
    output logic              o_ready,
    output cht_pkg::t_out_item o_item,
    output logic              o_empty,
    input  logic              i_pop
);
    import cht_pkg::*;

    localparam int NW = $clog2(POOL_NODES + 1);
    localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

    typedef enum logic [2:0] {
        S_IDLE, S_FREE, S_HEAD, S_READ, S_CHECK, S_RES
    } t_state;

    t_state r_state;
    t_job r_job;
    logic [NW-1:0] r_head [BUCKETS];
    logic r_used [POOL_NODES];
    logic [KEY_W-1:0] m_key [POOL_NODES];
    logic [63:0] m_lo [POOL_NODES];
    logic [55:0] m_hi [POOL_NODES];
    logic [NW-1:0] m_link [POOL_NODES];

    logic [NW-1:0] r_free, r_scan, r_cur, r_prev, r_steps;
    logic [KEY_W-1:0] r_rd_key;
    logic [63:0] r_rd_lo;
    logic [55:0] r_rd_hi;
    logic [NW-1:0] r_rd_link;
    t_out_item r_wrk;
    t_out_item r_out;
    logic r_full_q;
    logic [BW-1:0] w_b;
    logic w_load;

    assign w_b = BW'(r_job.bucket);
    assign o_ready = (r_state == S_IDLE);
    assign o_item = r_out;
    assign o_empty = !r_full_q;
    assign w_load = (r_state == S_RES) && (!r_full_q || i_pop);

    // node memory read, registered
    always_ff @(posedge i_clk) begin
        r_rd_key  <= m_key[r_cur[IW-1:0]];
        r_rd_lo   <= m_lo[r_cur[IW-1:0]];
        r_rd_hi   <= m_hi[r_cur[IW-1:0]];
        r_rd_link <= m_link[r_cur[IW-1:0]];
    end

    // node memory write ports
    always_ff @(posedge i_clk) begin
        if (r_state == S_HEAD && r_job.operation == OP_INSERT) begin
            m_key[r_free[IW-1:0]]  <= r_job.record_key;
            m_lo[r_free[IW-1:0]]   <= r_job.name_low;
            m_hi[r_free[IW-1:0]]   <= r_job.name_high;
            m_link[r_free[IW-1:0]] <= NIL;
        end else if (r_state == S_CHECK && r_job.operation == OP_INSERT
                     && r_rd_link == NIL) begin
            m_link[r_cur[IW-1:0]] <= r_free;
        end else if (r_state == S_CHECK && r_job.operation == OP_DELETE
                     && r_rd_key == r_job.record_key && r_prev != NIL) begin
            m_link[r_prev[IW-1:0]] <= r_rd_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_full_q <= 1'b0;
            for (int i = 0; i < BUCKETS; i++) r_head[i] <= NIL;
            for (int i = 0; i < POOL_NODES; i++) r_used[i] <= 1'b0;
        end else begin
            if (w_load) begin
                r_full_q <= 1'b1;
                r_out <= r_wrk;
            end else if (i_pop) begin
                r_full_q <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job <= i_job;
                        r_wrk.status <= ST_MISS;
                        r_wrk.bucket <= i_job.bucket;
                        r_wrk.found_name_low <= '0;
                        r_wrk.found_name_high <= '0;
                        r_scan <= '0;
                        r_free <= NIL;
                        r_state <= (i_job.operation == OP_INSERT) ? S_FREE : S_HEAD;
                    end
                end
                S_FREE: begin
                    // scan for lowest free node, one per cycle
                    if (r_scan == NIL) begin
                        r_wrk.status <= ST_FULL;
                        r_state <= S_RES;
                    end else if (!r_used[r_scan[IW-1:0]]) begin
                        r_free <= r_scan;
                        r_state <= S_HEAD;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_HEAD: begin
                    r_cur <= r_head[w_b];
                    r_prev <= NIL;
                    r_steps <= '0;
                    if (r_job.operation == OP_INSERT) begin
                        r_used[r_free[IW-1:0]] <= 1'b1;
                        r_wrk.status <= ST_DONE;
                        if (r_head[w_b] == NIL) begin
                            r_head[w_b] <= r_free;
                            r_state <= S_RES;
                        end else begin
                            r_state <= S_READ;
                        end
                    end else if (r_job.operation == OP_DELETE
                                 || r_job.operation == OP_SEARCH) begin
                        r_state <= (r_head[w_b] == NIL) ? S_RES : S_READ;
                    end else begin
                        r_state <= S_RES;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_job.operation == OP_INSERT) begin
                        if (r_rd_link == NIL || r_steps == NIL - 1'b1) begin
                            r_state <= S_RES;
                        end else begin
                            r_cur <= r_rd_link;
                            r_steps <= r_steps + 1'b1;
                            r_state <= S_READ;
                        end
                    end else if (r_rd_key == r_job.record_key) begin
                        r_wrk.status <= ST_DONE;
                        if (r_job.operation == OP_SEARCH) begin
                            r_wrk.found_name_low <= r_rd_lo;
                            r_wrk.found_name_high <= r_rd_hi;
                        end else begin
                            if (r_prev == NIL) r_head[w_b] <= r_rd_link;
                            r_used[r_cur[IW-1:0]] <= 1'b0;
                        end
                        r_state <= S_RES;
                    end else if (r_rd_link == NIL || r_steps == NIL - 1'b1) begin
                        r_state <= S_RES;
                    end else begin
                        r_prev <= r_cur;
                        r_cur <= r_rd_link;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_RES: begin
                    // hold until the output register is free
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> sv/chained_hash_table.sv
// Top level of the chained hash table
// Use: push an operation (insert, delete, search) with its key and, for
// insert, a 15-character name while full is low. One result beat comes
// back per operation, in order, on the result side while empty is low;
// pop takes it.
// Path: the front end reduces the key to a bucket (a registered reciprocal
// remainder against BUCKETS), a queue hop, then the back end. A search or
// delete walks the chain from the head node; each chain node takes a
// registered node memory read. Insert scans the pool for the lowest free
// node at one node a cycle and walks to the chain tail.
// Flow: one operation at a time in the back end. A result register holds
// the finished beat; when the receiver stalls the back end waits with the
// next result and the front end and queue keep filling until full rises.
// Reset empties every chain and frees every node at once; no clearing
// pass is needed.
module chained_hash_table #(
    parameter int BUCKETS = 9,
    parameter int POOL_NODES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cht_pkg::t_in_item  i_item,
    input  logic               push,
    output logic               full,
    output cht_pkg::t_out_item o_item,
    output logic               empty,
    input  logic               pop
);
    import cht_pkg::*;

    t_job w_fjob, w_qjob;
    logic w_fvalid, w_fready, w_qvalid, w_qready;

    cht_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk, .i_rst_n, .i_item, .i_push(push), .o_full(full),
        .o_job(w_fjob), .o_job_valid(w_fvalid), .i_job_ready(w_fready)
    );

    cht_queue u_queue (
        .i_clk, .i_rst_n, .i_job(w_fjob), .i_valid(w_fvalid), .o_ready(w_fready),
        .o_job(w_qjob), .o_valid(w_qvalid), .i_ready(w_qready)
    );

    cht_back #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES)) u_back (
        .i_clk, .i_rst_n, .i_job(w_qjob), .i_valid(w_qvalid), .o_ready(w_qready),
        .o_item, .o_empty(empty), .i_pop(pop)
    );
endmodule

>>> sv/cht_checker.sv
// Port checker for the chained hash table
`include "chained_hash_table_macros.svh"
module cht_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input cht_pkg::t_in_item  i_item,
    input cht_pkg::t_out_item o_item
);
    import cht_pkg::*;

    `CHT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_item))
    `CHT_ASSERT_IMP(a_stat, i_clk, i_rst_n, !empty, o_item.status != 2'd3)
    `CHT_ASSERT_IMP(a_name0, i_clk, i_rst_n, !empty && o_item.status != ST_DONE,
        o_item.found_name_low == 64'd0 && o_item.found_name_high == 56'd0)
    `CHT_ASSERT_NEXT(a_busy, i_clk, i_rst_n, push && !full, full)
endmodule

bind chained_hash_table cht_checker u_cht_checker (
    .i_clk, .i_rst_n, .push, .full, .empty, .pop, .i_item, .o_item
);
